@@ rtl/nnta_pkg.sv @@
package nnta_pkg;

  // Field widths of the item channels and the configuration port
  localparam int IDX_W  = 6;
  localparam int POS_W  = 16;
  localparam int NUM_W  = 7;
  localparam int DMAX_W = 16;
  localparam int CFG_AW = 1;
  localparam int CFG_DW = 16;

  // Register indexes
  localparam logic [CFG_AW-1:0] CFG_NUM_POINTS = 1'd0;
  localparam logic [CFG_AW-1:0] CFG_DOMAIN_MAX = 1'd1;

  // Reset values of the registers
  localparam logic [NUM_W-1:0]  NUM_POINTS_RST = 7'd64;
  localparam logic [DMAX_W-1:0] DOMAIN_MAX_RST = 16'hFFFF;

  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_ASSIGN = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t                    cmd;
    logic [IDX_W-1:0]        point_index;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] query_index;
    logic             found;
    logic [IDX_W-1:0] target_index;
  } out_item_t;

  // Write strobes into one cell of the ring
  typedef struct packed {
    logic wr_pt;
    logic wr_tgt;
  } cell_ctl_t;

  // Scan unit control: capture the query point, present a candidate
  typedef struct packed {
    logic cap;
    logic cand;
  } scan_ctl_t;

  // Scan unit status
  typedef struct packed {
    logic pending;
    logic found;
  } scan_sts_t;

endpackage

@@ rtl/nnta_if.sv @@
interface nnta_if #(
  parameter type item_t = logic
);
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/nnta_cell.sv @@
module nnta_cell #(
  parameter int CW = 16,
  parameter int IW = 6
) (
  input  logic                clk,
  input  logic                rst_n,
  input  nnta_pkg::cell_ctl_t ctl,
  input  logic [3*CW-1:0]     nb_pt,
  input  logic [IW:0]         nb_tgt,
  input  logic [3*CW-1:0]     wr_pt_data,
  input  logic [IW:0]         wr_tgt_data,
  output logic [3*CW-1:0]     pt,
  output logic [IW:0]         tgt
);

  logic [3*CW-1:0] pt_r;
  logic [IW:0]     tgt_r;   // {valid, index}

  // Take the neighbor's point each cycle, or the loaded point
  always_ff @(posedge clk) begin
    pt_r <= ctl.wr_pt ? wr_pt_data : nb_pt;
  end

  // Take the neighbor's target; a load clears it, a scan result sets it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_r <= '0;
    end else if (ctl.wr_tgt) begin
      tgt_r <= wr_tgt_data;
    end else if (ctl.wr_pt) begin
      tgt_r <= '0;
    end else begin
      tgt_r <= nb_tgt;
    end
  end

  assign pt  = pt_r;
  assign tgt = tgt_r;

endmodule

@@ rtl/nnta_scan.sv @@
module nnta_scan #(
  parameter int CW = 16,
  parameter int IW = 6
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  nnta_pkg::scan_ctl_t         ctl,
  input  logic [3*CW-1:0]             head_pt,
  input  logic [IW-1:0]               head_idx,
  input  logic [nnta_pkg::DMAX_W-1:0] dmax,
  output nnta_pkg::scan_sts_t         sts,
  output logic [IW-1:0]               best_idx
);

  localparam int DW = 2 * CW + 2;
  localparam int BW = (DW > 32) ? DW : 32;

  logic [3*CW-1:0] qpt_r;
  logic            v1_r, v2_r, v3_r;
  logic [IW-1:0]   i1_r, i2_r, i3_r;
  logic [CW-1:0]   ad_r [3];
  logic [CW-1:0]   ad_nxt [3];
  logic [2*CW-1:0] sq_r [3];
  logic [DW-1:0]   d2_r;
  logic [BW-1:0]   best_d_r;
  logic [IW-1:0]   best_i_r;
  logic            found_r;
  logic [31:0]     dsq;
  logic [BW-1:0]   d2x;
  logic            better;

  // Absolute coordinate differences against the captured query
  always_comb begin
    logic [CW:0] diff;
    for (int k = 0; k < 3; k++) begin
      diff = {head_pt[k*CW+CW-1], head_pt[k*CW +: CW]} -
             {qpt_r[k*CW+CW-1], qpt_r[k*CW +: CW]};
      ad_nxt[k] = diff[CW] ? CW'(~diff + 1'b1) : diff[CW-1:0];
    end
  end

  assign dsq    = 32'(dmax) * 32'(dmax);
  assign d2x    = BW'(d2_r);
  assign better = (d2x < best_d_r) ||
                  (found_r && (d2x == best_d_r) && (i3_r < best_i_r));

  // Stage valids and running best
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      found_r <= 1'b0;
    end else begin
      v1_r <= ctl.cand;
      v2_r <= v1_r;
      v3_r <= v2_r;
      if (ctl.cap) begin
        found_r <= 1'b0;
      end else if (v3_r && better) begin
        found_r <= 1'b1;
      end
    end
  end

  // Datapath: difference, square, sum, compare
  always_ff @(posedge clk) begin
    if (ctl.cap) begin
      qpt_r <= head_pt;
    end
    i1_r <= head_idx;
    i2_r <= i1_r;
    i3_r <= i2_r;
    for (int k = 0; k < 3; k++) begin
      ad_r[k] <= ad_nxt[k];
      sq_r[k] <= ad_r[k] * ad_r[k];
    end
    d2_r <= DW'(sq_r[0]) + DW'(sq_r[1]) + DW'(sq_r[2]);
    if (ctl.cap) begin
      best_d_r <= BW'(dsq);
      best_i_r <= '0;
    end else if (v3_r && better) begin
      best_d_r <= d2x;
      best_i_r <= i3_r;
    end
  end

  assign sts.pending = v1_r | v2_r | v3_r;
  assign sts.found   = found_r;
  assign best_idx    = best_i_r;

endmodule

@@ rtl/nearest_neighbor_target_assign_top.sv @@
// Nearest-neighbor target assignment over a ring of point cells.
// Input channel in_item (valid/ready): cmd load writes one point and clears
// its target; cmd assign scans all entries for the nearest qualifying point
// to the queried entry and records it as that entry's target.
// Output channel out_item carries one item per assign, none per load.
// Configuration: cfg_we/cfg_addr/cfg_wdata, to be written only while idle
// by the user; the block itself does not enforce it. The points rotate
// through MAX_POINTS cells, one step per cycle; a single distance unit at
// the head of the ring sees one entry per cycle.
// Load: accepted while idle; ready stays high, so loads go back to back.
// Assign: waits until the queried entry reaches the head, scans MAX_POINTS-1
// entries, drains the distance pipeline and writes back.
// Reset clears all targets to none at once; points are undefined until
// loaded. No clearing pass is needed.
// A result waits in the output register while the receiver stalls; loads
// are still taken meanwhile, and a finished assign holds until it is free.
module nearest_neighbor_target_assign_top #(
  parameter int MAX_POINTS  = 64,
  parameter int COORD_WIDTH = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [nnta_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [nnta_pkg::CFG_DW-1:0] cfg_wdata,
  nnta_if.sink                        in_item,
  nnta_if.source                      out_item
);

  localparam int CW    = COORD_WIDTH;
  localparam int IW    = $clog2(MAX_POINTS);
  localparam int XW    = ((IW > nnta_pkg::IDX_W) ? IW : nnta_pkg::IDX_W) + 1;
  localparam int NW    = IW + 1;
  localparam int POS_W = nnta_pkg::POS_W;
  localparam logic [IW-1:0] NM1 = IW'(MAX_POINTS - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WAIT,
    ST_SCAN,
    ST_DRAIN,
    ST_FIN
  } state_t;

  state_t                        state_r;
  logic [nnta_pkg::NUM_W-1:0]    num_r;
  logic [nnta_pkg::DMAX_W-1:0]   dmax_r;
  logic [IW-1:0]                 ph_r;
  logic [IW-1:0]                 q_r;
  logic [nnta_pkg::IDX_W-1:0]    qi_r;
  logic [IW-1:0]                 cnt_r;
  logic                          oob_r;
  logic                          out_valid_r;
  nnta_pkg::out_item_t           out_data_r;

  logic [3*CW-1:0]               pt_w  [MAX_POINTS];
  logic [IW:0]                   tgt_w [MAX_POINTS];
  nnta_pkg::cell_ctl_t           ctl_w [MAX_POINTS];
  logic [MAX_POINTS-1:0]         wr_pt_v, wr_tgt_v;

  logic                          accept, is_load, in_range, out_free;
  logic                          ld_we, tgt_we, cap, cand, found_o;
  logic [XW-1:0]                 qx, bx;
  logic [IW-1:0]                 q_in, q_sel, slot;
  logic [NW-1:0]                 sl_sum;
  logic [CW-1:0]                 cx, cy, cz;
  logic [3*CW-1:0]               ld_pt;
  logic [IW:0]                   wb_tgt;
  logic [IW-1:0]                 best_idx;
  nnta_pkg::scan_ctl_t           sctl;
  nnta_pkg::scan_sts_t           ssts;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_r  <= nnta_pkg::NUM_POINTS_RST;
      dmax_r <= nnta_pkg::DOMAIN_MAX_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        nnta_pkg::CFG_NUM_POINTS: num_r  <= cfg_wdata[nnta_pkg::NUM_W-1:0];
        nnta_pkg::CFG_DOMAIN_MAX: dmax_r <= cfg_wdata[nnta_pkg::DMAX_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance the ring phase: the head cell holds entry ph_r
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= '0;
    end else begin
      ph_r <= (ph_r == NM1) ? '0 : ph_r + 1'b1;
    end
  end

  // Input decode
  assign in_item.ready = (state_r == ST_IDLE);
  assign accept   = in_item.valid && in_item.ready;
  assign is_load  = (in_item.data.cmd == nnta_pkg::CMD_LOAD);
  assign qx       = XW'(in_item.data.point_index);
  assign q_in     = qx[IW-1:0];
  assign in_range = (qx < XW'(MAX_POINTS));
  assign out_free = !out_valid_r || out_item.ready;

  assign ld_we  = accept && is_load && in_range;
  assign tgt_we = (state_r == ST_FIN) && out_free && !oob_r;
  assign cap    = (state_r == ST_WAIT) && (ph_r == q_r);
  assign cand   = (state_r == ST_SCAN) && (XW'(ph_r) < XW'(num_r)) &&
                  !(tgt_w[0][IW] && (tgt_w[0][IW-1:0] == q_r));

  // Cell that holds the addressed entry after this edge
  assign q_sel  = (state_r == ST_IDLE) ? q_in : q_r;
  assign sl_sum = {1'b0, q_sel} + {1'b0, NM1} - {1'b0, ph_r};
  assign slot   = (sl_sum >= NW'(MAX_POINTS)) ? IW'(sl_sum - NW'(MAX_POINTS))
                                              : sl_sum[IW-1:0];

  // Sign-extend or narrow the loaded coordinates
  generate
    if (CW <= POS_W) begin : g_narrow
      assign cx = in_item.data.pos_x[CW-1:0];
      assign cy = in_item.data.pos_y[CW-1:0];
      assign cz = in_item.data.pos_z[CW-1:0];
    end else begin : g_wide
      assign cx = {{(CW-POS_W){in_item.data.pos_x[POS_W-1]}}, in_item.data.pos_x};
      assign cy = {{(CW-POS_W){in_item.data.pos_y[POS_W-1]}}, in_item.data.pos_y};
      assign cz = {{(CW-POS_W){in_item.data.pos_z[POS_W-1]}}, in_item.data.pos_z};
    end
  endgenerate

  assign ld_pt  = {cz, cy, cx};
  assign wb_tgt = {ssts.found, best_idx};

  // Ring of point cells, each handing its entry to the previous one
  generate
    for (genvar k = 0; k < MAX_POINTS; k++) begin : g_cell
      assign wr_pt_v[k]    = ld_we && (slot == IW'(k));
      assign wr_tgt_v[k]   = tgt_we && (slot == IW'(k));
      assign ctl_w[k].wr_pt  = wr_pt_v[k];
      assign ctl_w[k].wr_tgt = wr_tgt_v[k];

      nnta_cell #(
        .CW (CW),
        .IW (IW)
      ) u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl_w[k]),
        .nb_pt       (pt_w[(k + 1) % MAX_POINTS]),
        .nb_tgt      (tgt_w[(k + 1) % MAX_POINTS]),
        .wr_pt_data  (ld_pt),
        .wr_tgt_data (wb_tgt),
        .pt          (pt_w[k]),
        .tgt         (tgt_w[k])
      );
    end
  endgenerate

  // Distance unit at the head of the ring
  assign sctl.cap  = cap;
  assign sctl.cand = cand;

  nnta_scan #(
    .CW (CW),
    .IW (IW)
  ) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (sctl),
    .head_pt  (pt_w[0]),
    .head_idx (ph_r),
    .dmax     (dmax_r),
    .sts      (ssts),
    .best_idx (best_idx)
  );

  assign found_o = !oob_r && ssts.found;
  assign bx      = XW'(best_idx);

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_item.ready && !((state_r == ST_FIN) && out_free)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (accept && !is_load) begin
            qi_r  <= in_item.data.point_index;
            q_r   <= q_in;
            oob_r <= !in_range;
            state_r <= in_range ? ST_WAIT : ST_FIN;
          end
        end
        ST_WAIT: begin
          if (cap) begin
            cnt_r   <= IW'(1);
            state_r <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (cnt_r == NM1) begin
            state_r <= ST_DRAIN;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        ST_DRAIN: begin
          if (!ssts.pending) begin
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            out_valid_r             <= 1'b1;
            out_data_r.query_index  <= qi_r;
            out_data_r.found        <= found_o;
            out_data_r.target_index <= found_o ? bx[nnta_pkg::IDX_W-1:0] : '0;
            state_r                 <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_item.valid = out_valid_r;
  assign out_item.data  = out_data_r;

`ifndef ASSERT_OFF
  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({wr_pt_v, wr_tgt_v}))
    else $error("more than one cell written in a cycle");

  a_fin_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN) |-> !ssts.pending)
    else $error("result taken while distance pipeline still busy");

  a_no_self: assert property (@(posedge clk) disable iff (!rst_n)
    (out_item.valid && out_item.data.found && (IW <= nnta_pkg::IDX_W)) |->
      (out_item.data.target_index != out_item.data.query_index))
    else $error("entry assigned to itself");
`endif

endmodule

@@ tb/nearest_neighbor_target_assign_checker.sv @@
module nearest_neighbor_target_assign_checker
  import nnta_pkg::*;
#(
  parameter int MAX_POINTS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CFG_AW-1:0]   cfg_addr,
  input  logic [CFG_DW-1:0]   cfg_wdata,
  input  logic                in_valid,
  input  logic                in_ready,
  input  in_item_t            in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  out_item_t           out_data,
  output int                  fail_count,
  output int                  pending
);

  // Shadow copy of the point table, the target table and the registers
  logic signed [POS_W-1:0] pos_x_q [MAX_POINTS];
  logic signed [POS_W-1:0] pos_y_q [MAX_POINTS];
  logic signed [POS_W-1:0] pos_z_q [MAX_POINTS];
  logic                    tgt_set [MAX_POINTS];
  logic [IDX_W-1:0]        tgt_of  [MAX_POINTS];
  logic [NUM_W-1:0]        num_points_q;
  logic [DMAX_W-1:0]       domain_max_q;

  // Nearest-target answers still owed by the block, oldest first
  out_item_t nearest_q [$];
  int        mismatches = 0;
  int        owed = 0;

  assign fail_count = mismatches;
  assign pending    = owed;

  function automatic longint sq_distance(int a, int b);
    longint dx, dy, dz;
    dx = longint'(pos_x_q[a]) - longint'(pos_x_q[b]);
    dy = longint'(pos_y_q[a]) - longint'(pos_y_q[b]);
    dz = longint'(pos_z_q[a]) - longint'(pos_z_q[b]);
    return dx * dx + dy * dy + dz * dz;
  endfunction

  // Scan the active entries for the closest qualifying point and record it
  function automatic out_item_t predict_nearest(logic [IDX_W-1:0] q);
    out_item_t res;
    longint    best_d2;
    longint    d2;
    int        n;
    res.query_index  = q;
    res.found        = 1'b0;
    res.target_index = '0;
    n = (num_points_q > MAX_POINTS) ? MAX_POINTS : int'(num_points_q);
    best_d2 = longint'(domain_max_q) * longint'(domain_max_q);
    for (int i = 0; i < n; i++) begin
      // skip the point itself and points already aiming at it
      if (i == int'(q)) continue;
      if (tgt_set[i] && tgt_of[i] == q) continue;
      d2 = sq_distance(int'(q), i);
      // strict compare keeps the lower index on a tie
      if (d2 < best_d2) begin
        best_d2          = d2;
        res.found        = 1'b1;
        res.target_index = IDX_W'(i);
      end
    end
    tgt_set[q] = res.found;
    tgt_of[q]  = res.target_index;
    return res;
  endfunction

  always @(posedge clk) begin : track
    out_item_t want;
    if (!rst_n) begin
      for (int i = 0; i < MAX_POINTS; i++) begin
        tgt_set[i] = 1'b0;
        tgt_of[i]  = '0;
      end
      num_points_q = NUM_POINTS_RST;
      domain_max_q = DOMAIN_MAX_RST;
      nearest_q.delete();
    end else begin
      // Follow register writes
      if (cfg_we) begin
        case (cfg_addr)
          CFG_NUM_POINTS: num_points_q = cfg_wdata[NUM_W-1:0];
          CFG_DOMAIN_MAX: domain_max_q = cfg_wdata[DMAX_W-1:0];
          default: ;
        endcase
      end

      // Compare each delivered item with the oldest answer owed
      if (out_valid && out_ready) begin
        if (nearest_q.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result: q=%0d found=%0d target=%0d",
                     out_data.query_index, out_data.found, out_data.target_index);
          mismatches++;
        end else begin
          want = nearest_q.pop_front();
          if (out_data.query_index !== want.query_index ||
              out_data.found !== want.found ||
              out_data.target_index !== want.target_index) begin
            if (mismatches < 10)
              $display("mismatch: expected q=%0d found=%0d target=%0d, got q=%0d found=%0d target=%0d",
                       want.query_index, want.found, want.target_index,
                       out_data.query_index, out_data.found, out_data.target_index);
            mismatches++;
          end
        end
      end

      // Apply each accepted item to the shadow tables
      if (in_valid && in_ready) begin
        if (in_data.cmd == CMD_LOAD) begin
          pos_x_q[in_data.point_index] = in_data.pos_x;
          pos_y_q[in_data.point_index] = in_data.pos_y;
          pos_z_q[in_data.point_index] = in_data.pos_z;
          tgt_set[in_data.point_index] = 1'b0;
          tgt_of[in_data.point_index]  = '0;
        end else begin
          nearest_q.push_back(predict_nearest(in_data.point_index));
        end
      end
    end
    owed = nearest_q.size();
  end

endmodule

@@ tb/nearest_neighbor_target_assign_top_tb.sv @@
module nearest_neighbor_target_assign_top_tb;
  import nnta_pkg::*;

  localparam int MAX_POINTS    = 64;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 2 * MAX_POINTS + 8;
  localparam int NUM_PHASES    = 9;

  typedef enum int {
    RX_OPEN,
    RX_COIN,
    RX_PERIODIC,
    RX_CHOKED
  } rx_mode_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  logic [CFG_AW-1:0] cfg_addr;
  logic [CFG_DW-1:0] cfg_wdata;
  int                fail_count;
  int                pending;

  // Entries written so far, and the scan length now in force
  logic [MAX_POINTS-1:0] loaded = '0;
  int                    cur_n = MAX_POINTS;

  nnta_if #(.item_t(in_item_t))  in_item ();
  nnta_if #(.item_t(out_item_t)) out_item ();

  nearest_neighbor_target_assign_top #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_WIDTH(POS_W)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .in_item  (in_item),
    .out_item (out_item)
  );

  nearest_neighbor_target_assign_checker #(
    .MAX_POINTS(MAX_POINTS)
  ) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_item.valid),
    .in_ready  (in_item.ready),
    .in_data   (in_item.data),
    .out_valid (out_item.valid),
    .out_ready (out_item.ready),
    .out_data  (out_item.data),
    .fail_count(fail_count),
    .pending   (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver: switch between open, coin-flip, periodic and choked stretches
  initial begin : receiver
    rx_mode_t mode;
    int       mode_left;
    int       tick;
    mode      = RX_OPEN;
    mode_left = 0;
    tick      = 0;
    out_item.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        mode      = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      tick++;
      case (mode)
        RX_OPEN:     out_item.ready <= 1'b1;
        RX_COIN:     out_item.ready <= 1'($urandom_range(0, 1));
        RX_PERIODIC: out_item.ready <= ((tick % 7) >= 3);
        default:     out_item.ready <= ($urandom_range(0, 9) == 0);
      endcase
    end
  end

  // Watchdog
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("[nearest_neighbor_target_assign_top] ERROR");
    $finish;
  end

  function automatic in_item_t item_of(cmd_t cmd, int idx, int x, int y, int z);
    in_item_t it;
    it.cmd         = cmd;
    it.point_index = IDX_W'(idx);
    it.pos_x       = POS_W'(x);
    it.pos_y       = POS_W'(y);
    it.pos_z       = POS_W'(z);
    return it;
  endfunction

  // Coordinates: a coarse grid for ties, a local cloud, full range, extremes
  function automatic logic signed [POS_W-1:0] rand_coord();
    logic signed [POS_W-1:0] c;
    case ($urandom_range(0, 3))
      0: c = POS_W'(16 * $urandom_range(0, 4)) - POS_W'(32);
      1: c = POS_W'($urandom_range(0, 4000)) - POS_W'(2000);
      2: c = POS_W'($urandom);
      default: begin
        case ($urandom_range(0, 3))
          0: c = 16'sh8000;
          1: c = 16'sh7FFF;
          2: c = '0;
          default: c = -16'sd1;
        endcase
      end
    endcase
    return c;
  endfunction

  // Pick a load or an assign that never reads an unwritten entry
  function automatic in_item_t make_item();
    in_item_t              it;
    logic [MAX_POINTS-1:0] need;
    int                    q;
    it.pos_x = rand_coord();
    it.pos_y = rand_coord();
    it.pos_z = rand_coord();
    q = $urandom_range(0, MAX_POINTS - 1);
    need = (cur_n >= MAX_POINTS) ? '1 : ((MAX_POINTS'(1) << cur_n) - MAX_POINTS'(1));
    if ((loaded & need) != need) begin
      it.cmd = CMD_LOAD;
      if ($urandom_range(0, 3) != 0) begin
        for (int i = MAX_POINTS - 1; i >= 0; i--)
          if (need[i] && !loaded[i]) q = i;
      end
    end else if (loaded[q] && $urandom_range(0, 99) < 55) begin
      it.cmd = CMD_ASSIGN;
    end else begin
      it.cmd = CMD_LOAD;
    end
    it.point_index = IDX_W'(q);
    return it;
  endfunction

  // Hold the item until the block takes it
  task automatic send_item(in_item_t it);
    in_item.valid <= 1'b1;
    in_item.data  <= it;
    if (it.cmd == CMD_LOAD) loaded[it.point_index] = 1'b1;
    do @(posedge clk); while (!in_item.ready);
  endtask

  // Write both registers back to back
  task automatic set_config(int num, int dmax);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_NUM_POINTS;
    cfg_wdata <= CFG_DW'(num);
    @(posedge clk);
    cfg_addr  <= CFG_DOMAIN_MAX;
    cfg_wdata <= CFG_DW'(dmax);
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_n = (num > MAX_POINTS) ? MAX_POINTS : num;
  endtask

  // Stop sending, wait for every owed answer, then let the block go quiet
  task automatic drain();
    in_item.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Random items in bursts with random gaps
  task automatic run_random(int count);
    int sent;
    int burst;
    sent = 0;
    while (sent < count) begin
      burst = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 24);
      while (burst > 0 && sent < count) begin
        send_item(make_item());
        sent++;
        burst--;
      end
      in_item.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  initial begin : stimulus
    int phase_num   [NUM_PHASES] = '{64, 127, 0, 1, 8, 33, 17, 64, 5};
    int phase_dmax  [NUM_PHASES] = '{65535, 2500, 300, 65535, 40, 700, 0, 100, 65535};
    int phase_items [NUM_PHASES] = '{120, 80, 30, 40, 60, 80, 40, 80, 60};
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_addr      <= '0;
    cfg_wdata     <= '0;
    in_item.valid <= 1'b0;
    in_item.data  <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Small table: ties, mutual targets, extreme coordinates and indexes
    set_config(3, 65535);
    send_item(item_of(CMD_LOAD, 0, 0, 0, 0));
    send_item(item_of(CMD_LOAD, 1, 16, 0, 0));
    send_item(item_of(CMD_LOAD, 2, -16, 0, 0));
    send_item(item_of(CMD_ASSIGN, 0, 0, 0, 0));
    send_item(item_of(CMD_ASSIGN, 1, 0, 0, 0));
    send_item(item_of(CMD_ASSIGN, 2, 0, 0, 0));
    send_item(item_of(CMD_LOAD, 63, 32767, 32767, 32767));
    send_item(item_of(CMD_LOAD, 3, -32768, -32768, -32768));
    send_item(item_of(CMD_ASSIGN, 63, 0, 0, 0));
    send_item(item_of(CMD_ASSIGN, 3, -1, -1, -1));
    send_item(item_of(CMD_LOAD, 1, 16, 0, 0));
    send_item(item_of(CMD_ASSIGN, 0, 0, 0, 0));
    drain();

    // Candidate exactly at the domain limit is rejected, one past is taken
    set_config(2, 16);
    send_item(item_of(CMD_ASSIGN, 0, 0, 0, 0));
    drain();
    set_config(2, 17);
    send_item(item_of(CMD_ASSIGN, 0, 0, 0, 0));
    drain();

    // Empty scan
    set_config(0, 65535);
    send_item(item_of(CMD_ASSIGN, 1, 0, 0, 0));
    drain();

    // Random phases across register settings
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p == 5) begin
        phase_num[p]  = $urandom_range(2, 63);
        phase_dmax[p] = $urandom_range(0, 65535);
      end
      set_config(phase_num[p], phase_dmax[p]);
      run_random(phase_items[p]);
      drain();
    end

    if (fail_count == 0)
      $display("[nearest_neighbor_target_assign_top] OK");
    else
      $display("[nearest_neighbor_target_assign_top] ERROR");
    $finish;
  end

endmodule

@@ files.f @@
rtl/nnta_pkg.sv
rtl/nnta_if.sv
rtl/nnta_cell.sv
rtl/nnta_scan.sv
rtl/nearest_neighbor_target_assign_top.sv
tb/nearest_neighbor_target_assign_checker.sv
tb/nearest_neighbor_target_assign_top_tb.sv
